[hw/rtl/risp_pkg.sv]
// Shared types, constants and character helpers for the radix integer string parser.
`timescale 1ns / 1ps

package risp_pkg;

    // Default sizing of the parser
    localparam int MAX_CHARS_DEF     = 1024;
    localparam int HIGHEST_RADIX_DEF = 36;

    // Fixed field widths
    localparam int CH_W    = 8;
    localparam int DATA_W  = 64;
    localparam int RADIX_W = 6;
    localparam int STOP_W  = 11;
    localparam int CFG_W   = 2;

    // Well-known bases
    localparam logic [RADIX_W-1:0] RADIX_AUTO  = 6'd0;
    localparam logic [RADIX_W-1:0] RADIX_BIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_OCT   = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX   = 6'd16;
    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_DEC;

    // Configuration register indexes
    localparam logic [CFG_W-1:0] CFG_RADIX          = 2'd0;
    localparam logic [CFG_W-1:0] CFG_MAX_VALUE      = 2'd1;
    localparam logic [CFG_W-1:0] CFG_OVERFLOW_VALUE = 2'd2;

    // Characters of interest
    localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CH_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CH_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CH_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [CH_W-1:0] CH_UP_B   = 8'h42;
    localparam logic [CH_W-1:0] CH_UP_X   = 8'h58;
    localparam logic [CH_W-1:0] CH_UP_Z   = 8'h5A;
    localparam logic [CH_W-1:0] CH_LO_A   = 8'h61;
    localparam logic [CH_W-1:0] CH_LO_B   = 8'h62;
    localparam logic [CH_W-1:0] CH_LO_X   = 8'h78;
    localparam logic [CH_W-1:0] CH_LO_Z   = 8'h7A;

    // Value reported for a byte that is no digit at all
    localparam logic [6:0] DIGIT_NONE = 7'd99;

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_SIGNED,
        PH_ZERO,
        PH_PREFIX,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK,
        ST_NO_DIGITS,
        ST_OVERFLOW,
        ST_BAD_BASE
    } t_status;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            last;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] magnitude;
        logic              negative;
        t_status           status;
        logic [STOP_W-1:0] stop_index;
    } t_out_item;

    // Digit worth of a byte, case-insensitive letters worth 10..35
    function automatic logic [6:0] digit_value(logic [CH_W-1:0] c);
        logic [6:0] v;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            v = 7'(c - CH_ZERO);
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            v = 7'(c - CH_LO_A + 8'd10);
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            v = 7'(c - CH_UP_A + 8'd10);
        end else begin
            v = DIGIT_NONE;
        end
        return v;
    endfunction

    function automatic logic base_ok(logic [RADIX_W-1:0] b, int hi);
        return (b >= RADIX_BIN) && (int'(b) <= hi);
    endfunction

    function automatic logic is_digit_of(logic [CH_W-1:0] c, logic [RADIX_W-1:0] b, int hi);
        return base_ok(b, hi) && (digit_value(c) < {1'b0, b});
    endfunction

endpackage

[hw/rtl/radix_integer_string_parser_unit.sv]
// Top level of the streaming radix integer string parser.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  in      | input     | i_in_valid/o_in_ready | i_in_data  (t_in_item: ch, last)
//  out     | output    | o_out_valid/i_out_ready| o_out_data (magnitude, negative, status,
//          |           |                       |             stop_index)
//  cfg     | input     | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
//  One character per cycle unless a last character stalls: a transaction enters the input register,
//  is parsed there, and a string result is in the output register at the edge that ends its parse.
//  The clock is set by the accumulator loop: one 64x6 multiply-add and a 71-bit compare.
//  A string result waits in the output register; only a last character stalls behind it.
//  Reset (synchronous, active low) restores radix 10, all-ones limits and empty parse state.
//  Configuration writes are taken in every cycle.
`timescale 1ns / 1ps

module radix_integer_string_parser_unit
    import risp_pkg::*;
#(
    parameter int MAX_CHARS     = MAX_CHARS_DEF,
    parameter int HIGHEST_RADIX = HIGHEST_RADIX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_index,
    input  logic [DATA_W-1:0] i_cfg_data
);

    localparam int                POS_W   = $clog2(MAX_CHARS + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_CHARS);
    localparam int                MAC_W   = DATA_W + RADIX_W + 1;

    // Configuration registers
    logic [RADIX_W-1:0] r_radix;
    logic [DATA_W-1:0]  r_max_value;
    logic [DATA_W-1:0]  r_overflow_value;

    // Input and output registers
    logic      r_in_valid, n_in_valid;
    t_in_item  r_in, n_in;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    // Per-string parse state
    t_phase             r_phase, n_phase;
    logic               r_minus, n_minus;
    logic [RADIX_W-1:0] r_base, n_base;
    logic [DATA_W-1:0]  r_acc, n_acc;
    logic               r_any_digit, n_any_digit;
    logic               r_overflowed, n_overflowed;
    logic [POS_W-1:0]   r_char_pos, n_char_pos;
    logic [POS_W-1:0]   r_stop_pos, n_stop_pos;

    // Phase walk results
    t_phase             w_phase;
    logic [RADIX_W-1:0] w_base;
    logic               w_sign_hit;
    logic               w_zero_hit;
    logic               w_digit_hit;

    logic               w_advance;
    logic [CH_W-1:0]    w_ch;
    logic [MAC_W-1:0]   w_mac;
    logic               w_mac_over;
    logic [POS_W-1:0]   w_next_pos;
    logic [RADIX_W-1:0] w_final_base;
    t_out_item          w_result;

    assign w_ch        = r_in.ch;
    assign w_advance   = r_in_valid && (!r_in.last || !r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix          <= RADIX_RESET;
            r_max_value      <= '1;
            r_overflow_value <= '1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RADIX:          r_radix          <= i_cfg_data[RADIX_W-1:0];
                CFG_MAX_VALUE:      r_max_value      <= i_cfg_data;
                CFG_OVERFLOW_VALUE: r_overflow_value <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Walk the phases for the current character (next-state logic)
    always_comb begin
        t_phase             ph;
        logic [RADIX_W-1:0] b;
        logic               handled;
        ph          = r_phase;
        b           = r_base;
        handled     = 1'b0;
        w_sign_hit  = 1'b0;
        w_zero_hit  = 1'b0;
        w_digit_hit = 1'b0;

        if (ph == PH_SKIP) begin
            if (w_ch == CH_SPACE || (w_ch >= CH_TAB && w_ch <= CH_CR)) begin
                handled = 1'b1;
            end else if (w_ch == CH_PLUS || w_ch == CH_MINUS) begin
                w_sign_hit = 1'b1;
                ph         = PH_SIGNED;
                handled    = 1'b1;
            end else begin
                ph = PH_SIGNED;
            end
        end

        if (!handled && ph == PH_SIGNED) begin
            if (w_ch == CH_ZERO && (r_radix == RADIX_AUTO || r_radix == RADIX_BIN ||
                                    r_radix == RADIX_HEX)) begin
                w_zero_hit = 1'b1;
                b          = (r_radix == RADIX_AUTO) ? RADIX_OCT : r_radix;
                ph         = PH_ZERO;
                handled    = 1'b1;
            end else begin
                b  = (r_radix == RADIX_AUTO) ? RADIX_DEC : r_radix;
                ph = PH_DIGITS;
            end
        end

        if (!handled && ph == PH_ZERO) begin
            if ((r_radix == RADIX_AUTO || r_radix == RADIX_BIN) &&
                (w_ch == CH_LO_B || w_ch == CH_UP_B)) begin
                b       = RADIX_BIN;
                ph      = PH_PREFIX;
                handled = 1'b1;
            end else if ((r_radix == RADIX_AUTO || r_radix == RADIX_HEX) &&
                         (w_ch == CH_LO_X || w_ch == CH_UP_X)) begin
                b       = RADIX_HEX;
                ph      = PH_PREFIX;
                handled = 1'b1;
            end else begin
                ph = PH_DIGITS;
            end
        end

        // A prefix with no digit behind it backs up to the lone zero
        if (!handled && ph == PH_PREFIX) begin
            if (is_digit_of(w_ch, b, HIGHEST_RADIX)) begin
                ph = PH_DIGITS;
            end else begin
                ph      = PH_DONE;
                handled = 1'b1;
            end
        end

        if (!handled && ph == PH_DIGITS) begin
            if (is_digit_of(w_ch, b, HIGHEST_RADIX)) begin
                w_digit_hit = 1'b1;
            end else begin
                ph = PH_DONE;
            end
        end

        w_phase = ph;
        w_base  = b;
    end

    // Multiply-add one digit and check it against the limit
    assign w_mac      = ({(RADIX_W + 1)'(0), r_acc} * MAC_W'(w_base))
                        + MAC_W'(digit_value(w_ch));
    assign w_mac_over = w_mac > {(RADIX_W + 1)'(0), r_max_value};
    assign w_next_pos = (r_char_pos >= POS_MAX) ? POS_MAX : r_char_pos + 1'b1;

    // Updated string state and the result it gives (output logic)
    always_comb begin
        logic               s_minus;
        logic [DATA_W-1:0]  s_acc;
        logic               s_any;
        logic               s_ovf;
        logic [POS_W-1:0]   s_stop;
        s_minus = w_sign_hit ? (w_ch == CH_MINUS) : r_minus;
        s_any   = r_any_digit | w_zero_hit | w_digit_hit;
        s_ovf   = r_overflowed | (w_digit_hit & w_mac_over);
        s_stop  = (w_zero_hit || w_digit_hit) ? w_next_pos : r_stop_pos;
        if (w_zero_hit) begin
            s_acc = '0;
        end else if (w_digit_hit && !r_overflowed && !w_mac_over) begin
            s_acc = w_mac[DATA_W-1:0];
        end else begin
            s_acc = r_acc;
        end

        w_final_base = (w_phase == PH_SKIP || w_phase == PH_SIGNED)
                       ? ((r_radix == RADIX_AUTO) ? RADIX_DEC : r_radix)
                       : w_base;

        w_result = '{magnitude: '0, negative: 1'b0, status: ST_OK, stop_index: '0};
        if (!base_ok(w_final_base, HIGHEST_RADIX)) begin
            w_result.status = ST_BAD_BASE;
        end else if (!s_any) begin
            w_result.status = ST_NO_DIGITS;
        end else if (s_ovf) begin
            w_result.magnitude  = r_overflow_value;
            w_result.status     = ST_OVERFLOW;
            w_result.stop_index = STOP_W'(s_stop);
        end else begin
            w_result.magnitude  = s_acc;
            w_result.negative   = s_minus;
            w_result.stop_index = STOP_W'(s_stop);
        end

        // Hold by default
        n_phase      = r_phase;
        n_minus      = r_minus;
        n_base       = r_base;
        n_acc        = r_acc;
        n_any_digit  = r_any_digit;
        n_overflowed = r_overflowed;
        n_char_pos   = r_char_pos;
        n_stop_pos   = r_stop_pos;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_out_ready;

        if (w_advance) begin
            if (r_in.last) begin
                // Emit the result and clear the string state
                n_out        = w_result;
                n_out_valid  = 1'b1;
                n_phase      = PH_SKIP;
                n_minus      = 1'b0;
                n_base       = '0;
                n_acc        = '0;
                n_any_digit  = 1'b0;
                n_overflowed = 1'b0;
                n_char_pos   = '0;
                n_stop_pos   = '0;
            end else begin
                n_phase      = w_phase;
                n_minus      = s_minus;
                n_base       = w_base;
                n_acc        = s_acc;
                n_any_digit  = s_any;
                n_overflowed = s_ovf;
                n_char_pos   = w_next_pos;
                n_stop_pos   = s_stop;
            end
        end

        // Capture the next input transaction
        n_in_valid = r_in_valid && !w_advance;
        n_in       = r_in;
        if (i_in_valid && o_in_ready) begin
            n_in_valid = 1'b1;
            n_in       = i_in_data;
        end
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_phase      <= PH_SKIP;
            r_minus      <= 1'b0;
            r_base       <= '0;
            r_acc        <= '0;
            r_any_digit  <= 1'b0;
            r_overflowed <= 1'b0;
            r_char_pos   <= '0;
            r_stop_pos   <= '0;
        end else begin
            r_in_valid   <= n_in_valid;
            r_out_valid  <= n_out_valid;
            r_phase      <= n_phase;
            r_minus      <= n_minus;
            r_base       <= n_base;
            r_acc        <= n_acc;
            r_any_digit  <= n_any_digit;
            r_overflowed <= n_overflowed;
            r_char_pos   <= n_char_pos;
            r_stop_pos   <= n_stop_pos;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_out <= n_out;
    end

endmodule

[hw/rtl/risp_checker.sv]
// Port-level checker for the radix integer string parser, bound to its top level.
`timescale 1ns / 1ps

module risp_checker
    import risp_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input t_out_item         o_out_data
);

    // No result may be pending right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A failed parse reports zero magnitude, positive sign and index zero
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_BAD_BASE || o_out_data.status == ST_NO_DIGITS)
        |-> o_out_data.magnitude == '0 && !o_out_data.negative && o_out_data.stop_index == '0)
        else $error("failed parse carries data");

    // Only a clean parse may be negative
    a_neg_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.negative |-> o_out_data.status == ST_OK)
        else $error("negative result without ok status");

    // A successful parse consumed at least one character
    a_stop_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_OK || o_out_data.status == ST_OVERFLOW)
        |-> o_out_data.stop_index != '0)
        else $error("parsed number with zero stop index");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

endmodule

bind radix_integer_string_parser_unit risp_checker u_risp_checker (.*);
